>>> hdl/gfd_pkg.sv
// Shared types and constants for the gamepad frame decoder.
// No dependencies; used by gfd_stick_clamp and gamepad_frame_decoder.
package gfd_pkg;

  localparam int GFD_PAYLOAD_BYTES = 6;   // payload bytes between start and checksum
  localparam int GFD_HELD_DEPTH    = 6;   // buttons (2) + sticks (4)
  localparam int GFD_LATCH_N       = (GFD_PAYLOAD_BYTES < GFD_HELD_DEPTH) ?
                                     GFD_PAYLOAD_BYTES : GFD_HELD_DEPTH;
  localparam int GFD_POS_W         = $clog2(GFD_PAYLOAD_BYTES + 1);
  localparam int GFD_IDX_W         = (GFD_PAYLOAD_BYTES > 1) ? $clog2(GFD_PAYLOAD_BYTES) : 1;

  localparam int GFD_BYTE_W = 8;
  localparam int GFD_VAL_W  = 7;
  localparam int GFD_STICK_W = 8;
  localparam int GFD_CFG_IDX_W = 1;

  localparam logic [GFD_BYTE_W-1:0] GFD_START_BYTE   = 8'h80;
  localparam logic [GFD_VAL_W-1:0]  GFD_CENTER_RESET = 7'h40;
  localparam logic [GFD_VAL_W-1:0]  GFD_LIMIT_RESET  = 7'h40;

  // held frame slots
  localparam int GFD_SLOT_BTN_HI = 0;
  localparam int GFD_SLOT_BTN_LO = 1;
  localparam int GFD_SLOT_LX     = 2;
  localparam int GFD_SLOT_LY     = 3;
  localparam int GFD_SLOT_RX     = 4;
  localparam int GFD_SLOT_RY     = 5;

  localparam logic [GFD_CFG_IDX_W-1:0] GFD_CFG_CENTER = 1'b0;
  localparam logic [GFD_CFG_IDX_W-1:0] GFD_CFG_LIMIT  = 1'b1;

  typedef enum logic [1:0] {
    GFD_ST_OK      = 2'd0,
    GFD_ST_BAD_SUM = 2'd1,
    GFD_ST_OUTSIDE = 2'd2
  } gfd_status_t;

endpackage

>>> hdl/gfd_stick_clamp.sv
// Stick conditioning: subtract the centre value, clamp to +/- limit.
// Depends on gfd_pkg.
module gfd_stick_clamp (
  input  logic [gfd_pkg::GFD_VAL_W-1:0]          raw,
  input  logic [gfd_pkg::GFD_VAL_W-1:0]          center,
  input  logic [gfd_pkg::GFD_VAL_W-1:0]          limit,
  output logic signed [gfd_pkg::GFD_STICK_W-1:0] stick
);

  // two spare bits: difference and negated limit both fit comfortably
  localparam int W = gfd_pkg::GFD_VAL_W + 2;

  logic signed [W-1:0] diff;
  logic signed [W-1:0] lim_pos;
  logic signed [W-1:0] lim_neg;
  logic signed [W-1:0] clamped;

  always_comb begin
    diff    = signed'({2'b00, raw}) - signed'({2'b00, center});
    lim_pos = signed'({2'b00, limit});
    lim_neg = -lim_pos;
    priority if (diff > lim_pos) begin
      clamped = lim_pos;
    end else if (diff < lim_neg) begin
      clamped = lim_neg;
    end else begin
      clamped = diff;
    end
  end

  assign stick = clamped[gfd_pkg::GFD_STICK_W-1:0];

endmodule

>>> hdl/gamepad_frame_decoder.sv
// Gamepad frame decoder: each input transaction goes through the input register, then
// parse/latch/clamp into the result register. Throughput one byte per cycle,
// set by the single-pass parse between the two registers; stalls back-pressure through both.
// Reset (rst_n low, synchronous): hunting for a start byte, held buttons 0, held sticks 64,
// stick_center and stick_limit 64, both pipeline stages empty. Payload store is not reset.
// Depends on gfd_pkg and gfd_stick_clamp.
module gamepad_frame_decoder (
  input  logic                                     clk,
  input  logic                                     rst_n,
  // configuration write port
  input  logic                                     cfg_we,
  input  logic [gfd_pkg::GFD_CFG_IDX_W-1:0]        cfg_index,
  input  logic [gfd_pkg::GFD_VAL_W-1:0]            cfg_data,
  // byte input channel
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  logic [gfd_pkg::GFD_BYTE_W-1:0]           in_rx_byte,
  // result channel
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output logic [1:0]                               out_status,
  output logic                                     out_frame_done,
  output logic [gfd_pkg::GFD_VAL_W-1:0]            out_button_high,
  output logic [gfd_pkg::GFD_VAL_W-1:0]            out_button_low,
  output logic signed [gfd_pkg::GFD_STICK_W-1:0]   out_left_x,
  output logic signed [gfd_pkg::GFD_STICK_W-1:0]   out_left_y,
  output logic signed [gfd_pkg::GFD_STICK_W-1:0]   out_right_x,
  output logic signed [gfd_pkg::GFD_STICK_W-1:0]   out_right_y
);

  localparam int VW = gfd_pkg::GFD_VAL_W;
  localparam int SW = gfd_pkg::GFD_STICK_W;
  localparam int NP = gfd_pkg::GFD_PAYLOAD_BYTES;
  localparam int NH = gfd_pkg::GFD_HELD_DEPTH;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [VW-1:0] center_r;
  logic [VW-1:0] limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_r <= gfd_pkg::GFD_CENTER_RESET;
      limit_r  <= gfd_pkg::GFD_LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gfd_pkg::GFD_CFG_CENTER: center_r <= cfg_data;
        gfd_pkg::GFD_CFG_LIMIT:  limit_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline handshake. Stage 1 holds the received byte; stage 2 is the result
  // register. Stage 1 empties whenever the result register is free or being
  // taken this cycle, so a byte can enter every cycle.
  // ---------------------------------------------------------------------------
  logic                              in_valid_r;
  logic [gfd_pkg::GFD_BYTE_W-1:0]    in_byte_r;
  logic                              out_valid_r;
  logic                              adv;       // stage 2 can take stage 1
  logic                              proc;      // stage 1 byte parsed this cycle

  assign adv      = !out_valid_r || !out_stall;
  assign proc     = in_valid_r && adv;
  assign in_stall = in_valid_r && !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_byte_r <= in_rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= in_valid_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Frame parser state
  //   hunt_r : waiting for a start byte
  //   pos_r  : next payload slot, NP means checksum slot
  //   sum_r  : running 7-bit payload sum
  // ---------------------------------------------------------------------------
  logic                           hunt_r, hunt_nxt;
  logic [gfd_pkg::GFD_POS_W-1:0]  pos_r, pos_nxt;
  logic [VW-1:0]                  sum_r, sum_nxt;
  logic [VW-1:0]                  payload_r [NP];
  logic [VW-1:0]                  held_r    [NH];
  logic [VW-1:0]                  held_nxt  [NH];

  logic [VW-1:0]                  byte_lo;
  logic                           is_start;
  logic                           store_en;
  logic                           latch_en;
  gfd_pkg::gfd_status_t           status_nxt;
  logic                           done_nxt;

  assign byte_lo  = in_byte_r[VW-1:0];
  assign is_start = (in_byte_r == gfd_pkg::GFD_START_BYTE);

  // next-state and result codes
  always_comb begin
    hunt_nxt   = hunt_r;
    pos_nxt    = pos_r;
    sum_nxt    = sum_r;
    store_en   = 1'b0;
    latch_en   = 1'b0;
    status_nxt = gfd_pkg::GFD_ST_OK;
    done_nxt   = 1'b0;
    priority if (is_start) begin
      // start byte always restarts, even mid-frame or in the checksum slot
      hunt_nxt = 1'b0;
      pos_nxt  = '0;
      sum_nxt  = '0;
    end else if (hunt_r) begin
      status_nxt = gfd_pkg::GFD_ST_OUTSIDE;
    end else if (pos_r < gfd_pkg::GFD_POS_W'(NP)) begin
      store_en = 1'b1;
      pos_nxt  = pos_r + 1'b1;
      sum_nxt  = sum_r + byte_lo;   // wraps mod 128
    end else begin
      // checksum slot
      if (sum_r == byte_lo) begin
        latch_en = 1'b1;
        done_nxt = 1'b1;
      end else begin
        status_nxt = gfd_pkg::GFD_ST_BAD_SUM;
      end
      hunt_nxt = 1'b1;
      pos_nxt  = '0;
    end
  end

  // held frame as it stands after this byte; slots beyond the payload keep their value
  always_comb begin
    for (int i = 0; i < NH; i++) begin
      held_nxt[i] = held_r[i];
    end
    if (latch_en) begin
      for (int i = 0; i < gfd_pkg::GFD_LATCH_N; i++) begin
        held_nxt[i] = payload_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hunt_r <= 1'b1;
      pos_r  <= '0;
      sum_r  <= '0;
    end else if (proc) begin
      hunt_r <= hunt_nxt;
      pos_r  <= pos_nxt;
      sum_r  <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && store_en) begin
      payload_r[pos_r[gfd_pkg::GFD_IDX_W-1:0]] <= byte_lo;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NH; i++) begin
        held_r[i] <= (i < 2) ? '0 : gfd_pkg::GFD_CENTER_RESET;
      end
    end else if (proc) begin
      for (int i = 0; i < NH; i++) begin
        held_r[i] <= held_nxt[i];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stick conditioning on the held frame after this byte
  // ---------------------------------------------------------------------------
  logic signed [SW-1:0] lx_c, ly_c, rx_c, ry_c;

  gfd_stick_clamp u_clamp_lx (
    .raw(held_nxt[gfd_pkg::GFD_SLOT_LX]), .center(center_r), .limit(limit_r), .stick(lx_c)
  );
  gfd_stick_clamp u_clamp_ly (
    .raw(held_nxt[gfd_pkg::GFD_SLOT_LY]), .center(center_r), .limit(limit_r), .stick(ly_c)
  );
  gfd_stick_clamp u_clamp_rx (
    .raw(held_nxt[gfd_pkg::GFD_SLOT_RX]), .center(center_r), .limit(limit_r), .stick(rx_c)
  );
  gfd_stick_clamp u_clamp_ry (
    .raw(held_nxt[gfd_pkg::GFD_SLOT_RY]), .center(center_r), .limit(limit_r), .stick(ry_c)
  );

  // ---------------------------------------------------------------------------
  // Result register (payload, no reset)
  // ---------------------------------------------------------------------------
  gfd_pkg::gfd_status_t  status_r;
  logic                  done_r;
  logic [VW-1:0]         btn_hi_r, btn_lo_r;
  logic signed [SW-1:0]  lx_r, ly_r, rx_r, ry_r;

  always_ff @(posedge clk) begin
    if (proc) begin
      status_r <= status_nxt;
      done_r   <= done_nxt;
      btn_hi_r <= held_nxt[gfd_pkg::GFD_SLOT_BTN_HI];
      btn_lo_r <= held_nxt[gfd_pkg::GFD_SLOT_BTN_LO];
      lx_r     <= lx_c;
      ly_r     <= ly_c;
      rx_r     <= rx_c;
      ry_r     <= ry_c;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_frame_done  = done_r;
  assign out_button_high = btn_hi_r;
  assign out_button_low  = btn_lo_r;
  assign out_left_x      = lx_r;
  assign out_left_y      = ly_r;
  assign out_right_x     = rx_r;
  assign out_right_y     = ry_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // a completed frame is always reported as ok
  a_done_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && done_r |-> status_r == gfd_pkg::GFD_ST_OK)
    else $error("frame_done with non-ok status");

  // input back-pressure only when the result register is full and held
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r && out_stall)
    else $error("input stalled without a held result");

  // after a good checksum the parser goes back to hunting
  a_hunt_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    proc && done_nxt |=> hunt_r && pos_r == '0)
    else $error("parser not hunting after a completed frame");

  // payload position never passes the checksum slot
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= gfd_pkg::GFD_POS_W'(NP))
    else $error("payload position out of range");

endmodule

>>> dv/gfd_frame_checker.sv
// Scoreboard for gamepad_frame_decoder: watches the config port and both channels,
// predicts each result from its own copy of the decoder state and compares field by field.
// Depends on gfd_pkg.
`timescale 1ns / 1ps

module gfd_frame_checker (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [gfd_pkg::GFD_CFG_IDX_W-1:0]      cfg_index,
  input  logic [gfd_pkg::GFD_VAL_W-1:0]          cfg_data,
  input  logic                                   in_valid,
  input  logic                                   in_stall,
  input  logic [gfd_pkg::GFD_BYTE_W-1:0]         in_rx_byte,
  input  logic                                   out_valid,
  input  logic                                   out_stall,
  input  logic [1:0]                             out_status,
  input  logic                                   out_frame_done,
  input  logic [gfd_pkg::GFD_VAL_W-1:0]          out_button_high,
  input  logic [gfd_pkg::GFD_VAL_W-1:0]          out_button_low,
  input  logic signed [gfd_pkg::GFD_STICK_W-1:0] out_left_x,
  input  logic signed [gfd_pkg::GFD_STICK_W-1:0] out_left_y,
  input  logic signed [gfd_pkg::GFD_STICK_W-1:0] out_right_x,
  input  logic signed [gfd_pkg::GFD_STICK_W-1:0] out_right_y,
  output int                                     fail_count,
  output int                                     pending,
  output int                                     frames_latched,
  output int                                     results_checked
);

  typedef struct packed {
    gfd_pkg::gfd_status_t                   status;
    logic                                   done;
    logic [gfd_pkg::GFD_VAL_W-1:0]          btn_hi;
    logic [gfd_pkg::GFD_VAL_W-1:0]          btn_lo;
    logic signed [gfd_pkg::GFD_STICK_W-1:0] lx;
    logic signed [gfd_pkg::GFD_STICK_W-1:0] ly;
    logic signed [gfd_pkg::GFD_STICK_W-1:0] rx;
    logic signed [gfd_pkg::GFD_STICK_W-1:0] ry;
  } frame_result_t;

  logic [gfd_pkg::GFD_VAL_W-1:0] centre_q;
  logic [gfd_pkg::GFD_VAL_W-1:0] limit_q;
  bit                            hunting;
  int unsigned                   byte_pos;
  logic [gfd_pkg::GFD_VAL_W-1:0] payload_q [gfd_pkg::GFD_PAYLOAD_BYTES];
  logic [gfd_pkg::GFD_VAL_W-1:0] held_q    [gfd_pkg::GFD_HELD_DEPTH];
  frame_result_t                 expected_results [$];
  int                            mismatches;
  int                            n_latched;
  int                            n_checked;

  function automatic logic signed [gfd_pkg::GFD_STICK_W-1:0] centre_clamp(
    input logic [gfd_pkg::GFD_VAL_W-1:0] raw);
    int v;
    int lim;
    v   = int'(raw) - int'(centre_q);
    lim = int'(limit_q);
    if (v > lim) v = lim;
    if (v < -lim) v = -lim;
    return v[gfd_pkg::GFD_STICK_W-1:0];
  endfunction

  function automatic frame_result_t predict_byte(input logic [gfd_pkg::GFD_BYTE_W-1:0] b);
    frame_result_t r;
    int unsigned   sum;
    r.status = gfd_pkg::GFD_ST_OK;
    r.done   = 1'b0;
    if (b == gfd_pkg::GFD_START_BYTE) begin
      hunting  = 1'b0;
      byte_pos = 0;
    end else if (hunting) begin
      r.status = gfd_pkg::GFD_ST_OUTSIDE;
    end else if (byte_pos < gfd_pkg::GFD_PAYLOAD_BYTES) begin
      payload_q[byte_pos] = b[gfd_pkg::GFD_VAL_W-1:0];
      byte_pos++;
    end else begin
      sum = 0;
      for (int i = 0; i < gfd_pkg::GFD_PAYLOAD_BYTES; i++) sum += payload_q[i];
      if ((sum & 'h7F) == b[gfd_pkg::GFD_VAL_W-1:0]) begin
        for (int i = 0; i < gfd_pkg::GFD_LATCH_N; i++) held_q[i] = payload_q[i];
        r.done = 1'b1;
        n_latched++;
      end else begin
        r.status = gfd_pkg::GFD_ST_BAD_SUM;
      end
      hunting  = 1'b1;
      byte_pos = 0;
    end
    r.btn_hi = held_q[gfd_pkg::GFD_SLOT_BTN_HI];
    r.btn_lo = held_q[gfd_pkg::GFD_SLOT_BTN_LO];
    r.lx     = centre_clamp(held_q[gfd_pkg::GFD_SLOT_LX]);
    r.ly     = centre_clamp(held_q[gfd_pkg::GFD_SLOT_LY]);
    r.rx     = centre_clamp(held_q[gfd_pkg::GFD_SLOT_RX]);
    r.ry     = centre_clamp(held_q[gfd_pkg::GFD_SLOT_RY]);
    return r;
  endfunction

  task automatic compare_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  task automatic check_result();
    frame_result_t e;
    if (expected_results.size() == 0) begin
      $error("unexpected result transaction: status %0d", out_status);
      mismatches++;
    end else begin
      e = expected_results.pop_front();
      n_checked++;
      compare_field("status", int'(e.status), int'(out_status));
      compare_field("frame_done", int'(e.done), int'(out_frame_done));
      compare_field("button_high", int'(e.btn_hi), int'(out_button_high));
      compare_field("button_low", int'(e.btn_lo), int'(out_button_low));
      compare_field("left_x", int'(e.lx), int'(out_left_x));
      compare_field("left_y", int'(e.ly), int'(out_left_y));
      compare_field("right_x", int'(e.rx), int'(out_right_x));
      compare_field("right_y", int'(e.ry), int'(out_right_y));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      centre_q = gfd_pkg::GFD_CENTER_RESET;
      limit_q  = gfd_pkg::GFD_LIMIT_RESET;
      hunting  = 1'b1;
      byte_pos = 0;
      for (int i = 0; i < gfd_pkg::GFD_HELD_DEPTH; i++)
        held_q[i] = (i < 2) ? '0 : gfd_pkg::GFD_CENTER_RESET;
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          gfd_pkg::GFD_CFG_CENTER: centre_q = cfg_data;
          gfd_pkg::GFD_CFG_LIMIT:  limit_q  = cfg_data;
          default: ;
        endcase
      end
      // drain first so a same-edge input never shadows an older expectation
      if (out_valid && !out_stall) check_result();
      if (in_valid && !in_stall) expected_results.push_back(predict_byte(in_rx_byte));
    end
    pending         <= expected_results.size();
    fail_count      <= mismatches;
    frames_latched  <= n_latched;
    results_checked <= n_checked;
  end

endmodule

>>> dv/tb_gamepad_frame_decoder.sv
// Top-level testbench for gamepad_frame_decoder: clock, reset, byte stimulus, result-side
// stalls and the verdict. Prediction and checking live in gfd_frame_checker.
// Depends on gfd_pkg, gfd_frame_checker and the decoder RTL.
`timescale 1ns / 1ps

module tb_gamepad_frame_decoder;

  localparam int LIMIT_CYCLES   = 100000; // far beyond the slowest legal run
  localparam int HOLD_CYCLES    = 48;     // long receiver hold-off, enough to back up both stages
  localparam int DRAIN_PAUSE    = 4;      // two-stage pipe, plus margin
  localparam int NUM_PHASES     = 6;
  localparam int RAND_PER_PHASE = 310;
  localparam int IDLE_PCT       = 22;

  logic                                   clk;
  logic                                   rst_n;
  logic                                   cfg_we;
  logic [gfd_pkg::GFD_CFG_IDX_W-1:0]      cfg_index;
  logic [gfd_pkg::GFD_VAL_W-1:0]          cfg_data;
  logic                                   in_valid;
  logic                                   in_stall;
  logic [gfd_pkg::GFD_BYTE_W-1:0]         in_rx_byte;
  logic                                   out_valid;
  logic                                   out_stall;
  logic [1:0]                             out_status;
  logic                                   out_frame_done;
  logic [gfd_pkg::GFD_VAL_W-1:0]          out_button_high;
  logic [gfd_pkg::GFD_VAL_W-1:0]          out_button_low;
  logic signed [gfd_pkg::GFD_STICK_W-1:0] out_left_x;
  logic signed [gfd_pkg::GFD_STICK_W-1:0] out_left_y;
  logic signed [gfd_pkg::GFD_STICK_W-1:0] out_right_x;
  logic signed [gfd_pkg::GFD_STICK_W-1:0] out_right_y;

  int fail_count;
  int pending;
  int frames_latched;
  int results_checked;

  // stimulus bookkeeping
  int                            bytes_sent;
  bit                            quiet_stretch;   // no idling on either side while set
  int                            holdoffs_asked;  // bumped by the sender, served by the stall process
  logic [gfd_pkg::GFD_VAL_W-1:0] cur_centre;
  logic [gfd_pkg::GFD_VAL_W-1:0] cur_limit;

  gamepad_frame_decoder i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_frame_done  (out_frame_done),
    .out_button_high (out_button_high),
    .out_button_low  (out_button_low),
    .out_left_x      (out_left_x),
    .out_left_y      (out_left_y),
    .out_right_x     (out_right_x),
    .out_right_y     (out_right_y)
  );

  gfd_frame_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_frame_done  (out_frame_done),
    .out_button_high (out_button_high),
    .out_button_low  (out_button_low),
    .out_left_x      (out_left_x),
    .out_left_y      (out_left_y),
    .out_right_x     (out_right_x),
    .out_right_y     (out_right_y),
    .fail_count      (fail_count),
    .pending         (pending),
    .frames_latched  (frames_latched),
    .results_checked (results_checked)
  );

  // 4 ns clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("tb_gamepad_frame_decoder: FAIL");
    $finish;
  end

  // Result-side stalls. Random ~22% back-pressure, none during the quiet stretch,
  // and a long solid hold-off whenever the sender asks for one.
  initial begin
    int holdoffs_served;
    holdoffs_served = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (holdoffs_served != holdoffs_asked) begin
        holdoffs_served = holdoffs_asked;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else if (quiet_stretch) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  // One byte transaction, optionally preceded by a short random gap. Valid stays
  // high across back-to-back bytes; only the gap lowers it. Each gap cycle is drawn
  // on its own, so the sender idles about 22 percent of the time.
  task automatic push_byte(input logic [gfd_pkg::GFD_BYTE_W-1:0] b);
    if (!quiet_stretch) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  // Sender pause until every predicted result has come back.
  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_PAUSE) @(posedge clk);
  endtask

  // Both stick registers, back to back; only called with the pipe empty.
  task automatic write_sticks(input logic [gfd_pkg::GFD_VAL_W-1:0] centre,
                              input logic [gfd_pkg::GFD_VAL_W-1:0] lim);
    cfg_we    <= 1'b1;
    cfg_index <= gfd_pkg::GFD_CFG_CENTER;
    cfg_data  <= centre;
    @(posedge clk);
    cfg_index <= gfd_pkg::GFD_CFG_LIMIT;
    cfg_data  <= lim;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_centre = centre;
    cur_limit  = lim;
  endtask

  // Start byte, payload, then checksum; a corrupted checksum differs in its low 7 bits.
  // Bit 7 of the checksum is randomised; the decoder ignores it, except that 8'h80 is a start byte.
  task automatic send_frame(input logic [gfd_pkg::GFD_BYTE_W-1:0] pl [gfd_pkg::GFD_PAYLOAD_BYTES],
                            input bit corrupt);
    int unsigned                    sum;
    logic [gfd_pkg::GFD_BYTE_W-1:0] chk;
    sum = 0;
    push_byte(gfd_pkg::GFD_START_BYTE);
    for (int i = 0; i < gfd_pkg::GFD_PAYLOAD_BYTES; i++) begin
      push_byte(pl[i]);
      sum += pl[i][gfd_pkg::GFD_VAL_W-1:0];
    end
    chk = {1'b0, sum[gfd_pkg::GFD_VAL_W-1:0]};
    if (corrupt)
      chk[gfd_pkg::GFD_VAL_W-1:0] = chk[gfd_pkg::GFD_VAL_W-1:0] ^ 7'($urandom_range(1, 127));
    chk[gfd_pkg::GFD_BYTE_W-1] = 1'($urandom_range(0, 1));
    push_byte(chk);
  endtask

  // Payload byte: extremes, values around the clamp edges of the current setting,
  // or anything but a start byte.
  function automatic logic [gfd_pkg::GFD_BYTE_W-1:0] pick_payload();
    int unsigned                    r;
    int                             v;
    logic [gfd_pkg::GFD_BYTE_W-1:0] b;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      case ($urandom_range(0, 3))
        0:       b = 8'h00;
        1:       b = 8'h7F;
        2:       b = 8'hFF;
        default: b = 8'h01;
      endcase
    end else if (r < 40) begin
      v = int'(cur_centre) + ($urandom_range(0, 1) ? int'(cur_limit) : -int'(cur_limit))
          + int'($urandom_range(0, 2)) - 1;
      if (v < 0) v = 0;
      if (v > 127) v = 127;
      b = {1'($urandom_range(0, 1)), v[gfd_pkg::GFD_VAL_W-1:0]};
    end else begin
      b = 8'($urandom_range(0, 255));
    end
    if (b == gfd_pkg::GFD_START_BYTE) b = 8'h00;
    return b;
  endfunction

  task automatic random_frame(input bit corrupt);
    logic [gfd_pkg::GFD_BYTE_W-1:0] pl [gfd_pkg::GFD_PAYLOAD_BYTES];
    for (int i = 0; i < gfd_pkg::GFD_PAYLOAD_BYTES; i++) pl[i] = pick_payload();
    send_frame(pl, corrupt);
  endtask

  // Mostly well-formed frames with random content; the rest is bad checksums,
  // frames cut short by a fresh start byte, and line noise.
  task automatic random_traffic(input int n);
    int          target;
    int unsigned r;
    target = bytes_sent + n;
    while (bytes_sent < target) begin
      r = $urandom_range(0, 99);
      if (r < 68) begin
        random_frame(1'b0);
        if ($urandom_range(0, 99) < 30)
          repeat ($urandom_range(1, 2)) push_byte(pick_payload());
      end else if (r < 80) begin
        random_frame(1'b1);
      end else if (r < 90) begin
        push_byte(gfd_pkg::GFD_START_BYTE);
        repeat ($urandom_range(0, gfd_pkg::GFD_PAYLOAD_BYTES - 1)) push_byte(pick_payload());
      end else begin
        repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    logic [gfd_pkg::GFD_BYTE_W-1:0] pl [gfd_pkg::GFD_PAYLOAD_BYTES];
    logic [gfd_pkg::GFD_VAL_W-1:0]  centres [NUM_PHASES];
    logic [gfd_pkg::GFD_VAL_W-1:0]  limits  [NUM_PHASES];

    bytes_sent     = 0;
    quiet_stretch  = 1'b0;
    holdoffs_asked = 0;
    cur_centre     = gfd_pkg::GFD_CENTER_RESET;
    cur_limit      = gfd_pkg::GFD_LIMIT_RESET;
    rst_n      <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_index  <= gfd_pkg::GFD_CFG_CENTER;
    cfg_data   <= '0;
    in_valid   <= 1'b0;
    in_rx_byte <= '0;

    // reset-time setting first, then the corners, then one random pick
    centres = '{gfd_pkg::GFD_CENTER_RESET, 7'd0, 7'd127, 7'd0, 7'd127,
                7'($urandom_range(0, 127))};
    limits  = '{gfd_pkg::GFD_LIMIT_RESET, 7'd127, 7'd0, 7'd0, 7'd127,
                7'($urandom_range(0, 127))};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // --- directed part, reset-time stick setting ---
    // noise before any start byte
    push_byte(8'h3C);
    push_byte(8'hFF);
    // good frame: high buttons all set, low buttons clear, sticks at both rails, a payload byte with bit 7 set
    pl = '{8'h7F, 8'h00, 8'h00, 8'h7F, 8'hFF, 8'h40};
    send_frame(pl, 1'b0);
    // stray byte after the checksum
    push_byte(8'h05);
    // full payload, then a start byte landing in the checksum slot restarts the frame
    push_byte(gfd_pkg::GFD_START_BYTE);
    pl = '{8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06};
    for (int i = 0; i < gfd_pkg::GFD_PAYLOAD_BYTES; i++) push_byte(pl[i]);
    push_byte(gfd_pkg::GFD_START_BYTE);
    // ...and that restarted frame then fails its checksum
    pl = '{8'h7F, 8'h7F, 8'h7F, 8'h7F, 8'h7F, 8'h7F};
    for (int i = 0; i < gfd_pkg::GFD_PAYLOAD_BYTES; i++) push_byte(pl[i]);
    push_byte(8'hFB);

    // --- random part, one stick setting per phase ---
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        wait_drain();
        write_sticks(centres[p], limits[p]);
      end
      if (p == 3) quiet_stretch = 1'b1;
      // long receiver hold-off while bytes keep coming, so the pipe backs up
      if (p == 1 || p == 4) holdoffs_asked++;
      random_traffic(RAND_PER_PHASE);
      if (p == 3) quiet_stretch = 1'b0;
    end

    wait_drain();
    repeat (DRAIN_PAUSE) @(posedge clk);

    $display("Run covered %0d byte transactions over %0d stick settings (corners included);",
             bytes_sent, NUM_PHASES);
    $display("%0d frames latched, %0d results compared.", frames_latched, results_checked);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_gamepad_frame_decoder: PASS");
    end else begin
      $display("tb_gamepad_frame_decoder: FAIL");
    end
    $finish;
  end

endmodule
